/* rtl/b64lw_pkg.sv */
// shared types, constants and the alphabet lookup for the base64 line-wrapped encoder
package b64lw_pkg;

    localparam int LINE_CHARS_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        GRP_0 = 2'd0,
        GRP_1 = 2'd1,
        GRP_2 = 2'd2
    } grp_pos_t;

    // one input byte worth of characters, slot 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26)
            begin
                c = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                c = 8'h61 + {2'b00, v - 6'd26};
            end
            else if (v < 6'd62)
            begin
                c = 8'h30 + {2'b00, v - 6'd52};
            end
            else if (v == 6'd62)
            begin
                c = 8'h2B;
            end
            else
            begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

/* rtl/base64_line_wrapped_encoder.sv */
// base64 encoder with line wrapping: byte stream in, ascii character stream out
// path: with an idle back end, a byte is first written into the queue and its first character
// is then loaded from the queue head into the output register that drives m_tdata
// throughput: one input transfer per cycle while the queue has room; one output
// character per cycle while m_tready is high, set by the single output register;
// a byte gives 1 to 4 characters, plus a line break where the line is full
// reset: rst_n asynchronous active low clears group, line and queue state; no clearing pass
module base64_line_wrapped_encoder
    import b64lw_pkg::*;
#(
    parameter int LINE_CHARS  = LINE_CHARS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // run_end
    output logic [0:0] m_tuser    // [0] message_end
);

    logic      push, pop;
    q_entry_t  push_entry, head;
    q_status_t q_status;
    logic      msg_end;

    b64lw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_fin     (s_tlast),
        .q_status   (q_status),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    b64lw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    b64lw_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (m_tdata),
        .out_run_end (m_tlast),
        .out_msg_end (msg_end)
    );

    assign m_tuser = msg_end;

endmodule

/* rtl/b64lw_front.sv */
// front end: accepts bytes, tracks the three-byte group and builds the character list
module b64lw_front
    import b64lw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [7:0] in_byte,
    input  logic      in_fin,
    input  q_status_t q_status,
    output logic      in_ready,
    output logic      push,
    output q_entry_t  push_entry
);

    grp_pos_t   pos_reg, pos_next;
    logic [3:0] left_reg, left_next;

    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    // group state
    always_comb
    begin
        pos_next  = pos_reg;
        left_next = left_reg;
        if (push)
        begin
            case (pos_reg)
                GRP_1:
                begin
                    pos_next  = GRP_2;
                    left_next = in_byte[3:0];
                end
                GRP_2:
                begin
                    pos_next  = GRP_0;
                    left_next = 4'd0;
                end
                default:
                begin
                    pos_next  = GRP_1;
                    left_next = {2'b00, in_byte[1:0]};
                end
            endcase
            if (in_fin)
            begin
                pos_next  = GRP_0;
                left_next = 4'd0;
            end
        end
    end

    // character list for this byte
    always_comb
    begin
        push_entry.chars    = {CHAR_PAD, CHAR_PAD, CHAR_PAD, CHAR_PAD};
        push_entry.last_idx = 2'd0;
        push_entry.fin      = in_fin;
        case (pos_reg)
            GRP_1:
            begin
                push_entry.chars[0] = b64_char({left_reg[1:0], in_byte[7:4]});
                push_entry.chars[1] = b64_char({in_byte[3:0], 2'b00});
                push_entry.last_idx = in_fin ? 2'd2 : 2'd0;
            end
            GRP_2:
            begin
                push_entry.chars[0] = b64_char({left_reg, in_byte[7:6]});
                push_entry.chars[1] = b64_char(in_byte[5:0]);
                push_entry.last_idx = 2'd1;
            end
            default:
            begin
                push_entry.chars[0] = b64_char(in_byte[7:2]);
                push_entry.chars[1] = b64_char({in_byte[1:0], 4'b0000});
                push_entry.last_idx = in_fin ? 2'd3 : 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= GRP_0;
            left_reg <= 4'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push && in_fin |=> pos_reg == GRP_0 && left_reg == 4'd0)
        else $error("group state not cleared after final byte");

endmodule

/* rtl/b64lw_queue.sv */
// short queue of per-byte character lists between front and back end
module b64lw_queue
    import b64lw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        begin
            if (p == PTR_W'(QUEUE_DEPTH - 1))
            begin
                r = '0;
            end
            else
            begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

    assign status.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH) && !(pop && status.empty))
        else $error("queue overrun or underrun");

endmodule

/* rtl/b64lw_back.sv */
// back end: walks each character list, inserts line breaks, drives the output register
module b64lw_back
    import b64lw_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_entry_t   head,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_run_end,
    output logic       out_msg_end
);

    localparam int LEN_W = $clog2(LINE_CHARS + 1);

    logic [LEN_W-1:0] col_cnt_reg, col_cnt_next;
    logic [1:0]       idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic             run_end_reg, run_end_next;
    logic             msg_end_reg, msg_end_next;

    logic slot_free, wrap, last_char, step;

    assign slot_free = !valid_reg || out_ready;
    assign wrap      = col_cnt_reg >= LEN_W'(LINE_CHARS);
    assign last_char = idx_reg == head.last_idx;
    assign step      = !q_status.empty && slot_free;
    assign pop       = step && !wrap && last_char;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        char_next    = char_reg;
        run_end_next = run_end_reg;
        msg_end_next = msg_end_reg;
        if (step)
        begin
            valid_next = 1'b1;
            if (wrap)
            begin
                // line full: break before the pending character
                char_next    = CHAR_NEWLINE;
                run_end_next = 1'b0;
                msg_end_next = 1'b0;
                col_cnt_next = '0;
            end
            else
            begin
                char_next    = head.chars[idx_reg];
                run_end_next = last_char;
                msg_end_next = last_char && head.fin;
                idx_next     = last_char ? 2'd0 : idx_reg + 1'b1;
                if (last_char && head.fin)
                begin
                    col_cnt_next = '0;
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + 1'b1;
                end
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            idx_reg     <= 2'd0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg    <= char_next;
        run_end_reg <= run_end_next;
        msg_end_reg <= msg_end_next;
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign out_run_end = run_end_reg;
    assign out_msg_end = msg_end_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        col_cnt_reg <= LEN_W'(LINE_CHARS))
        else $error("line counter past the line limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && char_reg == CHAR_NEWLINE |-> !run_end_reg && !msg_end_reg)
        else $error("line break marked as end of run");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && msg_end_reg |-> run_end_reg)
        else $error("message end without run end");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.fin |=> col_cnt_reg == '0 && idx_reg == 2'd0)
        else $error("line state not cleared after message");

endmodule

/* tb/sv/tb_base64_line_wrapped_encoder.sv */
// self-checking testbench for the base64 line-wrapped encoder with random stalls on both sides
module tb_base64_line_wrapped_encoder
    import b64lw_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TOTAL_BYTES  = 480;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] code;
        logic       run_end;
        logic       msg_end;
    } enc_char_t;

    // predicts the character stream and keeps the characters still owed by the block
    class char_scoreboard;
        enc_char_t  expected_chars[$];
        logic [3:0] spare_bits;
        grp_pos_t   grp;
        logic [6:0] col_count;
        int         errors;
        string      alphabet =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

        function new();
            spare_bits = '0;
            grp        = GRP_0;
            col_count  = '0;
            errors     = 0;
        endfunction

        function void push_raw(logic [7:0] code);
            enc_char_t e;
            e.code    = code;
            e.run_end = 1'b0;
            e.msg_end = 1'b0;
            expected_chars.insert(expected_chars.size(), e);
        endfunction

        // wrap before a character that would overrun the line
        function void push_char(logic [7:0] code);
            if (col_count >= LINE_CHARS_DEF)
            begin
                push_raw(CHAR_NEWLINE);
                col_count = '0;
            end
            push_raw(code);
            col_count = col_count + 7'd1;
        endfunction

        function void push_sextet(logic [5:0] v);
            push_char(8'(alphabet[int'(v)]));
        endfunction

        function void add_byte(logic [7:0] b, logic last_byte);
            int tail_idx;
            case (grp)
                GRP_1:
                begin
                    push_sextet({spare_bits[1:0], b[7:4]});
                    spare_bits = b[3:0];
                    grp        = GRP_2;
                    if (last_byte)
                    begin
                        push_sextet({b[3:0], 2'b00});
                        push_char(CHAR_PAD);
                    end
                end
                GRP_2:
                begin
                    push_sextet({spare_bits, b[7:6]});
                    push_sextet(b[5:0]);
                    spare_bits = '0;
                    grp        = GRP_0;
                end
                default:
                begin
                    push_sextet(b[7:2]);
                    spare_bits = {2'b00, b[1:0]};
                    grp        = GRP_1;
                    if (last_byte)
                    begin
                        push_sextet({b[1:0], 4'b0000});
                        push_char(CHAR_PAD);
                        push_char(CHAR_PAD);
                    end
                end
            endcase
            tail_idx = expected_chars.size() - 1;
            expected_chars[tail_idx].run_end = 1'b1;
            expected_chars[tail_idx].msg_end = last_byte;
            if (last_byte)
            begin
                spare_bits = '0;
                grp        = GRP_0;
                col_count  = '0;
            end
        endfunction

        function void check_char(logic [7:0] code, logic run_end, logic msg_end);
            enc_char_t e;
            if (expected_chars.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected char: code=%h run_end=%b msg_end=%b",
                             code, run_end, msg_end);
                return;
            end
            e = expected_chars.pop_front();
            if (e.code !== code || e.run_end !== run_end || e.msg_end !== msg_end)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"char mismatch: expected code=%h run_end=%b msg_end=%b, ",
                              "got code=%h run_end=%b msg_end=%b"},
                             e.code, e.run_end, e.msg_end, code, run_end, msg_end);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    char_scoreboard board;
    int             cycles;
    int             bytes_sent;
    int             send_mode;
    int             send_run;
    int             recv_mode;
    int             recv_run;

    base64_line_wrapped_encoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // idle pattern switches between none, short and long waits after random runs of 1 to 40 transfers
    function automatic int next_wait(inout int mode, inout int run);
        if (run <= 0)
        begin
            mode = $urandom_range(0, 2);
            run  = $urandom_range(1, 40);
        end
        run--;
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 19);
        endcase
    endfunction

    // valid stays high across back-to-back transfers
    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        int gap;
        gap = next_wait(send_mode, send_run);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last_byte;
        do
            @(posedge clk);
        while (!s_tready);
        board.add_byte(b, last_byte);
        bytes_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = next_wait(recv_mode, recv_run);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            board.check_char(m_tdata, m_tlast, m_tuser[0]);
        end
    end

    initial
    begin
        int len;
        int pick;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cycles     = 0;
        bytes_sent = 0;
        send_mode  = 0;
        send_run   = 0;
        recv_mode  = 0;
        recv_run   = 0;
        board      = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // one-byte messages: double padding
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte message: single padding
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // full groups, no padding
        send_byte(8'hFC, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 15; i++)
            send_byte(8'(i * 17), i == 14);

        // random messages of 1 to 130 bytes, so the longer ones cross the line limit
        while (bytes_sent < TOTAL_BYTES)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(1, 6);
            else if (pick < 9)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(45, 130);
            if (len > TOTAL_BYTES - bytes_sent)
                len = TOTAL_BYTES - bytes_sent;
            send_message(len);
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/b64lw_pkg.sv
rtl/b64lw_front.sv
rtl/b64lw_queue.sv
rtl/b64lw_back.sv
rtl/base64_line_wrapped_encoder.sv
tb/sv/tb_base64_line_wrapped_encoder.sv
